### hw/rtl/srpq_pkg.sv
// shared types and defaults for the shortest remaining priority queue
// no dependencies; used by the top level and its checker

package srpq_pkg;

    localparam int DEPTH_DEFAULT     = 16;
    localparam int ID_BITS_DEFAULT   = 16;
    localparam int TIME_BITS_DEFAULT = 16;

    // fixed widths of the request and result fields
    localparam int ID_W    = 16;
    localparam int TIME_W  = 16;
    localparam int COUNT_W = 5;
    localparam int TOTAL_W = 20;

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_REMOVE = 1'b1;

    typedef enum logic [4:0] {
        S_IDLE      = 5'b00001,
        S_INS_CMP   = 5'b00010,
        S_INS_LAST  = 5'b00100,
        S_REM_SHIFT = 5'b01000,
        S_FINISH    = 5'b10000
    } state_t;

endpackage

### hw/rtl/shortest_remaining_priority_queue.sv
// sorted priority queue, smallest remaining time first, smaller id on ties
// depends on srpq_pkg; entries live in a memory with one write port and one registered read port
//
// insert into n entries moves each larger entry up one slot, from the tail down,
//   remove of the head shifts the remaining entries down when n >= 2 entries were queued
// throughput: one request at a time; the next is accepted at the edge after the
//   result is registered; the cost is one memory entry per cycle through the one write port
// reset: count, total, served flag, sequencer and result valid clear at once;
//   the entry memory is not cleared, only slots below the count are ever read

module shortest_remaining_priority_queue #(
    parameter int DEPTH     = srpq_pkg::DEPTH_DEFAULT,
    parameter int ID_BITS   = srpq_pkg::ID_BITS_DEFAULT,
    parameter int TIME_BITS = srpq_pkg::TIME_BITS_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // request channel
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         action,
    input  logic [srpq_pkg::ID_W-1:0]    proc_id,
    input  logic [srpq_pkg::TIME_W-1:0]  remaining,
    // result channel
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [srpq_pkg::ID_W-1:0]    head_id,
    output logic [srpq_pkg::TIME_W-1:0]  head_remaining,
    output logic [srpq_pkg::COUNT_W-1:0] entry_count,
    output logic [srpq_pkg::TOTAL_W-1:0] total_remaining,
    output logic                         is_empty,
    output logic                         is_full,
    output logic                         removed_valid,
    output logic [srpq_pkg::ID_W-1:0]    removed_id,
    output logic [srpq_pkg::TIME_W-1:0]  removed_remaining,
    output logic                         insert_dropped,
    output logic                         served_flag
);

    localparam int AW    = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int TOT_W = TIME_BITS + CNT_W;

    // entry memory, kept sorted from slot 0 (head) upward
    logic [ID_BITS-1:0]   mem_ids   [DEPTH];
    logic [TIME_BITS-1:0] mem_times [DEPTH];

    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [ID_BITS-1:0]   wr_id;
    logic [TIME_BITS-1:0] wr_tm;
    logic [AW-1:0]        rd_addr;
    logic [ID_BITS-1:0]   rd_id_reg;
    logic [TIME_BITS-1:0] rd_tm_reg;

    srpq_pkg::state_t     state_reg, state_next;
    logic [CNT_W-1:0]     ptr_reg, ptr_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [TOT_W-1:0]     total_reg, total_next;
    logic                 served_reg, served_next;

    // the request being worked on and its side results
    logic [ID_BITS-1:0]   new_id_reg, new_id_next;
    logic [TIME_BITS-1:0] new_tm_reg, new_tm_next;
    logic [ID_BITS-1:0]   hd_id_reg, hd_id_next;
    logic [TIME_BITS-1:0] hd_tm_reg, hd_tm_next;
    logic                 rem_valid_reg, rem_valid_next;
    logic [ID_BITS-1:0]   rem_id_reg, rem_id_next;
    logic [TIME_BITS-1:0] rem_tm_reg, rem_tm_next;
    logic                 drop_reg, drop_next;

    // result register
    logic                          out_valid_reg, out_valid_next;
    logic                          res_load;
    logic [srpq_pkg::ID_W-1:0]     o_head_id_reg;
    logic [srpq_pkg::TIME_W-1:0]   o_head_tm_reg;
    logic [srpq_pkg::COUNT_W-1:0]  o_count_reg;
    logic [srpq_pkg::TOTAL_W-1:0]  o_total_reg;
    logic                          o_empty_reg;
    logic                          o_full_reg;
    logic                          o_rem_valid_reg;
    logic [srpq_pkg::ID_W-1:0]     o_rem_id_reg;
    logic [srpq_pkg::TIME_W-1:0]   o_rem_tm_reg;
    logic                          o_drop_reg;
    logic                          o_served_reg;

    logic                 accept;
    logic [ID_BITS-1:0]   in_id;
    logic [TIME_BITS-1:0] in_tm;
    logic [CNT_W-1:0]     count_m1;
    logic [CNT_W-1:0]     ptr_m1;
    logic [CNT_W-1:0]     ptr_m2;
    logic [CNT_W-1:0]     ptr_p1;
    logic                 entry_after;

    assign in_stall = (state_reg != srpq_pkg::S_IDLE);
    assign accept   = in_valid && !in_stall;

    // fields are held at the configured key widths
    assign in_id = ID_BITS'(proc_id);
    assign in_tm = TIME_BITS'(remaining);

    assign count_m1 = count_reg - CNT_W'(1);
    assign ptr_m1   = ptr_reg - CNT_W'(1);
    assign ptr_m2   = ptr_reg - CNT_W'(2);
    assign ptr_p1   = ptr_reg + CNT_W'(1);

    // the stored entry orders strictly after the new key: it has to move up
    assign entry_after = (rd_tm_reg > new_tm_reg) ||
                         ((rd_tm_reg == new_tm_reg) && (rd_id_reg > new_id_reg));

    // single write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_ids[wr_addr]   <= wr_id;
            mem_times[wr_addr] <= wr_tm;
        end
        rd_id_reg <= mem_ids[rd_addr];
        rd_tm_reg <= mem_times[rd_addr];
    end

    // sequencer: insertion walks down from the tail moving larger entries up
    // one slot a cycle; removal walks up from slot 1 moving entries down
    always_comb
    begin
        state_next     = state_reg;
        ptr_next       = ptr_reg;
        count_next     = count_reg;
        total_next     = total_reg;
        served_next    = served_reg;
        new_id_next    = new_id_reg;
        new_tm_next    = new_tm_reg;
        hd_id_next     = hd_id_reg;
        hd_tm_next     = hd_tm_reg;
        rem_valid_next = rem_valid_reg;
        rem_id_next    = rem_id_reg;
        rem_tm_next    = rem_tm_reg;
        drop_next      = drop_reg;
        wr_en          = 1'b0;
        wr_addr        = ptr_reg[AW-1:0];
        wr_id          = new_id_reg;
        wr_tm          = new_tm_reg;
        rd_addr        = ptr_m1[AW-1:0];
        res_load       = 1'b0;

        unique case (state_reg)
            srpq_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    new_id_next    = in_id;
                    new_tm_next    = in_tm;
                    rem_valid_next = 1'b0;
                    rem_id_next    = '0;
                    rem_tm_next    = '0;
                    drop_next      = 1'b0;
                    state_next     = srpq_pkg::S_FINISH;
                    if (action == srpq_pkg::ACT_INSERT)
                    begin
                        if (count_reg == CNT_W'(DEPTH))
                        begin
                            // full queue: request dropped, nothing changes
                            drop_next = 1'b1;
                        end
                        else
                        begin
                            count_next = count_reg + CNT_W'(1);
                            total_next = total_reg + TOT_W'(in_tm);
                            if (count_reg == '0)
                            begin
                                // empty queue: new entry is the head
                                wr_en      = 1'b1;
                                wr_addr    = '0;
                                wr_id      = in_id;
                                wr_tm      = in_tm;
                                hd_id_next = in_id;
                                hd_tm_next = in_tm;
                            end
                            else
                            begin
                                rd_addr    = count_m1[AW-1:0];
                                ptr_next   = count_reg;
                                state_next = srpq_pkg::S_INS_CMP;
                            end
                        end
                    end
                    else if (count_reg != '0)
                    begin
                        rem_valid_next = 1'b1;
                        rem_id_next    = hd_id_reg;
                        rem_tm_next    = hd_tm_reg;
                        count_next     = count_m1;
                        total_next     = total_reg - TOT_W'(hd_tm_reg);
                        served_next    = 1'b1;
                        if (count_reg > CNT_W'(1))
                        begin
                            rd_addr    = AW'(1);
                            ptr_next   = CNT_W'(1);
                            state_next = srpq_pkg::S_REM_SHIFT;
                        end
                    end
                end
            end
            srpq_pkg::S_INS_CMP:
            begin
                // read data holds the entry at slot ptr-1
                wr_en = 1'b1;
                if (entry_after)
                begin
                    wr_id = rd_id_reg;
                    wr_tm = rd_tm_reg;
                    ptr_next = ptr_m1;
                    if (ptr_reg > CNT_W'(1))
                    begin
                        rd_addr = ptr_m2[AW-1:0];
                    end
                    else
                    begin
                        state_next = srpq_pkg::S_INS_LAST;
                    end
                end
                else
                begin
                    state_next = srpq_pkg::S_FINISH;
                end
            end
            srpq_pkg::S_INS_LAST:
            begin
                // every entry moved up: new key takes the head slot
                wr_en      = 1'b1;
                wr_addr    = '0;
                hd_id_next = new_id_reg;
                hd_tm_next = new_tm_reg;
                state_next = srpq_pkg::S_FINISH;
            end
            srpq_pkg::S_REM_SHIFT:
            begin
                // read data holds slot ptr, moved down to ptr-1
                wr_en   = 1'b1;
                wr_addr = ptr_m1[AW-1:0];
                wr_id   = rd_id_reg;
                wr_tm   = rd_tm_reg;
                if (ptr_reg == CNT_W'(1))
                begin
                    hd_id_next = rd_id_reg;
                    hd_tm_next = rd_tm_reg;
                end
                if (ptr_reg < count_reg)
                begin
                    rd_addr  = ptr_p1[AW-1:0];
                    ptr_next = ptr_p1;
                end
                else
                begin
                    state_next = srpq_pkg::S_FINISH;
                end
            end
            srpq_pkg::S_FINISH:
            begin
                // hold until the result register is free
                if (!(out_valid_reg && out_stall))
                begin
                    res_load   = 1'b1;
                    state_next = srpq_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = srpq_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (res_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= srpq_pkg::S_IDLE;
            count_reg     <= '0;
            total_reg     <= '0;
            served_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            total_reg     <= total_next;
            served_reg    <= served_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // working payload, no reset needed
    always_ff @(posedge clk)
    begin
        ptr_reg       <= ptr_next;
        new_id_reg    <= new_id_next;
        new_tm_reg    <= new_tm_next;
        hd_id_reg     <= hd_id_next;
        hd_tm_reg     <= hd_tm_next;
        rem_valid_reg <= rem_valid_next;
        rem_id_reg    <= rem_id_next;
        rem_tm_reg    <= rem_tm_next;
        drop_reg      <= drop_next;
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            o_head_id_reg   <= (count_reg == '0) ? '0 : srpq_pkg::ID_W'(hd_id_reg);
            o_head_tm_reg   <= (count_reg == '0) ? '0 : srpq_pkg::TIME_W'(hd_tm_reg);
            o_count_reg     <= srpq_pkg::COUNT_W'(count_reg);
            o_total_reg     <= srpq_pkg::TOTAL_W'(total_reg);
            o_empty_reg     <= (count_reg == '0);
            o_full_reg      <= (count_reg == CNT_W'(DEPTH));
            o_rem_valid_reg <= rem_valid_reg;
            o_rem_id_reg    <= srpq_pkg::ID_W'(rem_id_reg);
            o_rem_tm_reg    <= srpq_pkg::TIME_W'(rem_tm_reg);
            o_drop_reg      <= drop_reg;
            o_served_reg    <= served_reg;
        end
    end

    assign out_valid         = out_valid_reg;
    assign head_id           = o_head_id_reg;
    assign head_remaining    = o_head_tm_reg;
    assign entry_count       = o_count_reg;
    assign total_remaining   = o_total_reg;
    assign is_empty          = o_empty_reg;
    assign is_full           = o_full_reg;
    assign removed_valid     = o_rem_valid_reg;
    assign removed_id        = o_rem_id_reg;
    assign removed_remaining = o_rem_tm_reg;
    assign insert_dropped    = o_drop_reg;
    assign served_flag       = o_served_reg;

endmodule

### hw/rtl/srpq_checker.sv
// port-level checks for the shortest remaining priority queue
// depends on srpq_pkg; bound to shortest_remaining_priority_queue below

module srpq_checker #(
    parameter int DEPTH = srpq_pkg::DEPTH_DEFAULT
) (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         out_valid,
    input logic                         out_stall,
    input logic [srpq_pkg::ID_W-1:0]    head_id,
    input logic [srpq_pkg::TIME_W-1:0]  head_remaining,
    input logic [srpq_pkg::COUNT_W-1:0] entry_count,
    input logic [srpq_pkg::TOTAL_W-1:0] total_remaining,
    input logic                         is_empty,
    input logic                         is_full,
    input logic                         removed_valid,
    input logic                         insert_dropped,
    input logic                         served_flag
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(head_id) &&
            $stable(entry_count) && $stable(total_remaining))
        else $error("stalled result changed");

    // an empty queue shows no head, no count and no total
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_empty |-> entry_count == '0 && head_id == '0 &&
            head_remaining == '0 && total_remaining == '0 && !is_full)
        else $error("empty result with queued data");

    // a removal marks the queue served from then on
    a_served: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && removed_valid |-> served_flag)
        else $error("removal without served flag");

    // a dropped insert means the queue was and stays full
    a_drop: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && insert_dropped |-> is_full && !removed_valid &&
            entry_count == srpq_pkg::COUNT_W'(DEPTH))
        else $error("insert dropped while not full");

endmodule

bind shortest_remaining_priority_queue srpq_checker #(.DEPTH(DEPTH)) u_srpq_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .head_id        (head_id),
    .head_remaining (head_remaining),
    .entry_count    (entry_count),
    .total_remaining(total_remaining),
    .is_empty       (is_empty),
    .is_full        (is_full),
    .removed_valid  (removed_valid),
    .insert_dropped (insert_dropped),
    .served_flag    (served_flag)
);

### bench/srpq_checker.sv
`timescale 1ns / 1ps
// result checker for the shortest remaining priority queue: watches both channels,
// keeps its own sorted copy of the queue and compares every result; uses srpq_pkg

module srpq_scoreboard (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic                         in_stall,
    input  logic                         action,
    input  logic [srpq_pkg::ID_W-1:0]    proc_id,
    input  logic [srpq_pkg::TIME_W-1:0]  remaining,
    input  logic                         out_valid,
    input  logic                         out_stall,
    input  logic [srpq_pkg::ID_W-1:0]    head_id,
    input  logic [srpq_pkg::TIME_W-1:0]  head_remaining,
    input  logic [srpq_pkg::COUNT_W-1:0] entry_count,
    input  logic [srpq_pkg::TOTAL_W-1:0] total_remaining,
    input  logic                         is_empty,
    input  logic                         is_full,
    input  logic                         removed_valid,
    input  logic [srpq_pkg::ID_W-1:0]    removed_id,
    input  logic [srpq_pkg::TIME_W-1:0]  removed_remaining,
    input  logic                         insert_dropped,
    input  logic                         served_flag,
    output int                           fail_count,
    output int                           pending,
    output int                           results_checked,
    output int                           drops_seen,
    output int                           empty_removes
);

    localparam int SLOTS = srpq_pkg::DEPTH_DEFAULT;

    typedef struct packed {
        logic [srpq_pkg::ID_W-1:0]    head_id;
        logic [srpq_pkg::TIME_W-1:0]  head_remaining;
        logic [srpq_pkg::COUNT_W-1:0] entry_count;
        logic [srpq_pkg::TOTAL_W-1:0] total_remaining;
        logic                         is_empty;
        logic                         is_full;
        logic                         removed_valid;
        logic [srpq_pkg::ID_W-1:0]    removed_id;
        logic [srpq_pkg::TIME_W-1:0]  removed_remaining;
        logic                         insert_dropped;
        logic                         served_flag;
    } queue_status_t;

    // sorted shadow of the queue
    logic [srpq_pkg::ID_W-1:0]   slot_id   [SLOTS];
    logic [srpq_pkg::TIME_W-1:0] slot_time [SLOTS];
    int                          fill;
    logic [20:0]                 time_sum;
    bit                          served;

    queue_status_t expected_status[$];
    int errs;
    int n_checked;
    int n_drops;
    int n_idle_removes;

    initial
    begin
        errs = 0;
        n_checked = 0;
        n_drops = 0;
        n_idle_removes = 0;
    end

    function automatic queue_status_t apply_request(input logic act,
                                                    input logic [srpq_pkg::ID_W-1:0] id,
                                                    input logic [srpq_pkg::TIME_W-1:0] tm);
        queue_status_t r;
        int pos;
        int k;
        r = '0;
        if (act == srpq_pkg::ACT_INSERT)
        begin
            if (fill >= SLOTS)
            begin
                r.insert_dropped = 1'b1;
                n_drops++;
            end
            else
            begin
                // new entry goes after every entry whose key is less or equal
                pos = 0;
                while (pos < fill && !(slot_time[pos] > tm ||
                       (slot_time[pos] == tm && slot_id[pos] > id)))
                    pos++;
                for (k = fill; k > pos; k--)
                begin
                    slot_id[k]   = slot_id[k-1];
                    slot_time[k] = slot_time[k-1];
                end
                slot_id[pos]   = id;
                slot_time[pos] = tm;
                fill++;
                time_sum = time_sum + 21'(tm);
            end
        end
        else if (fill > 0)
        begin
            r.removed_valid     = 1'b1;
            r.removed_id        = slot_id[0];
            r.removed_remaining = slot_time[0];
            for (k = 1; k < fill; k++)
            begin
                slot_id[k-1]   = slot_id[k];
                slot_time[k-1] = slot_time[k];
            end
            fill--;
            time_sum = time_sum - 21'(r.removed_remaining);
            served = 1'b1;
        end
        else
            n_idle_removes++;

        r.head_id         = (fill != 0) ? slot_id[0] : '0;
        r.head_remaining  = (fill != 0) ? slot_time[0] : '0;
        r.entry_count     = srpq_pkg::COUNT_W'(fill);
        r.total_remaining = time_sum[srpq_pkg::TOTAL_W-1:0];
        r.is_empty        = (fill == 0);
        r.is_full         = (fill == SLOTS);
        r.served_flag     = served;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            errs++;
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        queue_status_t want;
        if (!rst_n)
        begin
            fill = 0;
            time_sum = '0;
            served = 1'b0;
            expected_status.delete();
        end
        else
        begin
            // results belong to earlier requests, so check before taking a new one
            if (out_valid && !out_stall)
            begin
                if (expected_status.size() == 0)
                begin
                    errs++;
                    $error("result arrived with no request outstanding");
                end
                else
                begin
                    want = expected_status.pop_front();
                    check_field("head_id", 32'(want.head_id), 32'(head_id));
                    check_field("head_remaining", 32'(want.head_remaining),
                                32'(head_remaining));
                    check_field("entry_count", 32'(want.entry_count), 32'(entry_count));
                    check_field("total_remaining", 32'(want.total_remaining),
                                32'(total_remaining));
                    check_field("is_empty", 32'(want.is_empty), 32'(is_empty));
                    check_field("is_full", 32'(want.is_full), 32'(is_full));
                    check_field("removed_valid", 32'(want.removed_valid),
                                32'(removed_valid));
                    check_field("removed_id", 32'(want.removed_id), 32'(removed_id));
                    check_field("removed_remaining", 32'(want.removed_remaining),
                                32'(removed_remaining));
                    check_field("insert_dropped", 32'(want.insert_dropped),
                                32'(insert_dropped));
                    check_field("served_flag", 32'(want.served_flag), 32'(served_flag));
                    n_checked++;
                end
            end
            if (in_valid && !in_stall)
                expected_status.push_back(apply_request(action, proc_id, remaining));
        end
        fail_count      <= errs;
        pending         <= expected_status.size();
        results_checked <= n_checked;
        drops_seen      <= n_drops;
        empty_removes   <= n_idle_removes;
    end

endmodule

### bench/tb.sv
`timescale 1ns / 1ps
// top of the bench for the shortest remaining priority queue: clock, reset, request
// stimulus, random result stalls and the verdict; uses srpq_pkg and srpq_scoreboard

module tb;

    localparam int TOTAL_REQUESTS = 950;
    localparam int HOLD_CYCLES    = 200;   // one long receiver hold-off
    localparam int WATCHDOG_LIMIT = 2000;  // cycles with no handshake at all
    localparam int DRAIN_CYCLES   = 40;    // quiet time after the last result

    // how request keys are drawn
    typedef enum int { VAL_WIDE, VAL_TIES, VAL_TOP } value_style_t;
    // shape of one stretch of random requests
    typedef enum int { PH_FILL_DRAIN, PH_MIXED, PH_TIES } phase_kind_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;

    // request channel
    logic                          in_valid = 1'b0;
    logic                          in_stall;
    logic                          action = srpq_pkg::ACT_INSERT;
    logic [srpq_pkg::ID_W-1:0]     proc_id = '0;
    logic [srpq_pkg::TIME_W-1:0]   remaining = '0;

    // result channel
    logic                          out_valid;
    logic                          out_stall = 1'b0;
    logic [srpq_pkg::ID_W-1:0]     head_id;
    logic [srpq_pkg::TIME_W-1:0]   head_remaining;
    logic [srpq_pkg::COUNT_W-1:0]  entry_count;
    logic [srpq_pkg::TOTAL_W-1:0]  total_remaining;
    logic                          is_empty;
    logic                          is_full;
    logic                          removed_valid;
    logic [srpq_pkg::ID_W-1:0]     removed_id;
    logic [srpq_pkg::TIME_W-1:0]   removed_remaining;
    logic                          insert_dropped;
    logic                          served_flag;

    // checker feedback
    int fail_count;
    int pending;
    int results_checked;
    int drops_seen;
    int empty_removes;

    int  n_sent = 0;
    bit  gaps_on = 1'b1;
    bit  hold_req = 1'b0;
    bit  hold_done;
    int  stall_left;
    int  go_left;
    int  idle_cycles = 0;

    always #5 clk = ~clk;

    shortest_remaining_priority_queue dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .action            (action),
        .proc_id           (proc_id),
        .remaining         (remaining),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .head_id           (head_id),
        .head_remaining    (head_remaining),
        .entry_count       (entry_count),
        .total_remaining   (total_remaining),
        .is_empty          (is_empty),
        .is_full           (is_full),
        .removed_valid     (removed_valid),
        .removed_id        (removed_id),
        .removed_remaining (removed_remaining),
        .insert_dropped    (insert_dropped),
        .served_flag       (served_flag)
    );

    srpq_scoreboard u_scoreboard (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .action            (action),
        .proc_id           (proc_id),
        .remaining         (remaining),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .head_id           (head_id),
        .head_remaining    (head_remaining),
        .entry_count       (entry_count),
        .total_remaining   (total_remaining),
        .is_empty          (is_empty),
        .is_full           (is_full),
        .removed_valid     (removed_valid),
        .removed_id        (removed_id),
        .removed_remaining (removed_remaining),
        .insert_dropped    (insert_dropped),
        .served_flag       (served_flag),
        .fail_count        (fail_count),
        .pending           (pending),
        .results_checked   (results_checked),
        .drops_seen        (drops_seen),
        .empty_removes     (empty_removes)
    );

    // draw one 16-bit key; ties style keeps values tiny so ids and times collide,
    // top style piles up maximum values so the total reaches its ceiling
    function automatic logic [15:0] pick_key(input value_style_t style);
        logic [15:0] v;
        case (style)
            VAL_TIES: v = 16'($urandom_range(0, 3));
            VAL_TOP:  v = ($urandom_range(9) == 0) ? 16'($urandom) : 16'hFFFF;
            default:
            begin
                case ($urandom_range(9))
                    0:       v = 16'h0000;
                    1:       v = 16'hFFFF;
                    2:       v = 16'($urandom_range(0, 7));
                    default: v = 16'($urandom);
                endcase
            end
        endcase
        return v;
    endfunction

    // offer one request, hold it until taken, then maybe go quiet for a while
    task automatic offer_request(input logic act, input logic [srpq_pkg::ID_W-1:0] id,
                                 input logic [srpq_pkg::TIME_W-1:0] tm);
        int gap;
        int r;
        in_valid  <= 1'b1;
        action    <= act;
        proc_id   <= id;
        remaining <= tm;
        do
            @(posedge clk);
        while (in_stall);
        n_sent++;

        // mostly back to back, sometimes a short pause, rarely a long one
        gap = 0;
        if (gaps_on)
        begin
            r = $urandom_range(99);
            if (r >= 92)
                gap = $urandom_range(8, 40);
            else if (r >= 60)
                gap = $urandom_range(1, 3);
        end
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // stop offering and wait until every outstanding request has its result;
    // the extra edge lets the checker publish the request taken last
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // result-side stall pattern: short random stalls, occasional long stalls,
    // free-running stretches, and one forced hold-off requested by the stimulus
    always @(posedge clk or negedge rst_n)
    begin
        int r;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left = 0;
            go_left = 0;
            hold_done = 1'b0;
        end
        else
        begin
            if (hold_req && !hold_done)
            begin
                hold_done = 1'b1;
                stall_left = HOLD_CYCLES;
                go_left = 0;
            end
            else if (stall_left == 0 && go_left == 0)
            begin
                r = $urandom_range(99);
                if (r < 15)
                    go_left = $urandom_range(30, 120);
                else if (r < 25)
                begin
                    stall_left = $urandom_range(15, 50);
                    go_left = $urandom_range(0, 4);
                end
                else
                begin
                    stall_left = $urandom_range(0, 3);
                    go_left = $urandom_range(0, 4);
                end
            end

            if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else
            begin
                out_stall <= 1'b0;
                if (go_left > 0)
                    go_left--;
            end
        end
    end

    // watchdog: any handshake on either side counts as progress
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("timeout: no handshake for %0d cycles, %0d results outstanding",
                     idle_cycles, pending);
            $display("** shortest_remaining_priority_queue: FAILED **");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        int i;
        int n;
        int bias;
        value_style_t style;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part
        // remove on an empty queue: no change, served flag stays low
        offer_request(srpq_pkg::ACT_REMOVE, pick_key(VAL_WIDE), pick_key(VAL_WIDE));
        // smallest and largest keys
        offer_request(srpq_pkg::ACT_INSERT, 16'h0000, 16'h0000);
        offer_request(srpq_pkg::ACT_INSERT, 16'hFFFF, 16'hFFFF);
        // equal times: order falls back to the id, smaller first
        offer_request(srpq_pkg::ACT_INSERT, 16'h1234, 16'h8000);
        offer_request(srpq_pkg::ACT_INSERT, 16'h1233, 16'h8000);
        offer_request(srpq_pkg::ACT_INSERT, 16'h1235, 16'h8000);
        // exact duplicate of a queued entry
        offer_request(srpq_pkg::ACT_INSERT, 16'h1234, 16'h8000);
        // same time as the head, larger id lands behind it
        offer_request(srpq_pkg::ACT_INSERT, 16'hFFFF, 16'h0000);
        // first real removal sets the served flag
        offer_request(srpq_pkg::ACT_REMOVE, pick_key(VAL_WIDE), pick_key(VAL_WIDE));
        // descending times fill the queue up to the last slot
        for (i = 0; i < 10; i++)
            offer_request(srpq_pkg::ACT_INSERT, 16'hA5A5 ^ 16'(i), 16'(16'hFFFF - i));
        // insert into a full queue is dropped
        offer_request(srpq_pkg::ACT_INSERT, 16'h0001, 16'h0001);
        repeat (4) offer_request(srpq_pkg::ACT_REMOVE, pick_key(VAL_WIDE),
                                 pick_key(VAL_WIDE));

        // back pressure: the receiver holds off while requests keep coming,
        // so the block has to stall its request side
        hold_req <= 1'b1;
        gaps_on = 1'b0;
        repeat (8) offer_request(srpq_pkg::ACT_INSERT, pick_key(VAL_WIDE),
                                 pick_key(VAL_WIDE));
        // then the sender goes quiet until every result is back
        wait_drained();

        // random part, in stretches of different shapes
        while (n_sent < TOTAL_REQUESTS)
        begin
            gaps_on = ($urandom_range(3) != 0);
            case (phase_kind_t'($urandom_range(2)))
                PH_FILL_DRAIN:
                begin
                    // overfill then overdrain, hitting both full and empty
                    style = value_style_t'($urandom_range(2));
                    n = $urandom_range(17, 19);
                    repeat (n) offer_request(srpq_pkg::ACT_INSERT, pick_key(style),
                                             pick_key(style));
                    n = $urandom_range(17, 19);
                    repeat (n) offer_request(srpq_pkg::ACT_REMOVE, pick_key(VAL_WIDE),
                                             pick_key(VAL_WIDE));
                end
                PH_MIXED:
                begin
                    bias = $urandom_range(30, 70);
                    repeat (20)
                        offer_request(($urandom_range(99) < bias) ? srpq_pkg::ACT_INSERT
                                                                  : srpq_pkg::ACT_REMOVE,
                                      pick_key(VAL_WIDE), pick_key(VAL_WIDE));
                end
                default:
                begin
                    // tiny key space: plenty of equal times and duplicates
                    repeat (20)
                        offer_request(($urandom_range(99) < 60) ? srpq_pkg::ACT_INSERT
                                                                : srpq_pkg::ACT_REMOVE,
                                      pick_key(VAL_TIES), pick_key(VAL_TIES));
                end
            endcase
            if ($urandom_range(4) == 0)
                wait_drained();
        end

        // let everything come back, then watch for stray results
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("sent %0d requests and checked %0d results", n_sent, results_checked);
        $display("%0d inserts hit a full queue, %0d removes found it empty",
                 drops_seen, empty_removes);
        if (fail_count == 0 && pending == 0)
            $display("** shortest_remaining_priority_queue: PASSED **");
        else
            $display("** shortest_remaining_priority_queue: FAILED **");
        $finish;
    end

endmodule
